/* src/arbc_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// arbc_pkg
// Shared types and constants for the ARGB8888 rectangle blend compositor.
// ============================================================================
package arbc_pkg;

    localparam int PIX_W      = 32;
    localparam int CLIP_W     = 13;
    localparam int ALPHA_W    = 8;
    localparam int CHAN_W     = 8;
    localparam int CHAN_N     = 3;
    localparam int TYPE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ALPHA_W-1:0] ALPHA_FULL      = 8'hFF;
    localparam logic [ALPHA_W-1:0] ALPHA_NONE      = 8'h00;
    localparam logic [CHAN_W-1:0]  OPAQUE_BYTE     = 8'hFF;
    localparam logic [PIX_W-1:0]   SRC_COLOR_RESET = 32'h0000_0000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_COLOR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONST_ALPHA  = 3'd5;

    typedef enum logic [TYPE_W-1:0] {
        REQ_FILL  = 2'd0,
        REQ_CONST = 2'd1,
        REQ_COVER = 2'd2
    } req_t;

    // Decision for one pixel: copy the source, blend, or pass through
    typedef struct packed {
        logic               take_src;
        logic               take_mix;
        logic [ALPHA_W-1:0] alpha;
    } ctrl_t;

endpackage

/* src/arbc_decide.sv */
`timescale 1ns / 1ps
// ============================================================================
// arbc_decide
// Clip rectangle test and per-mode choice of source copy, blend or pass.
// ============================================================================
module arbc_decide
    import arbc_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  logic [TYPE_W-1:0]      req_type,
    input  logic [COORD_WIDTH-1:0] pixel_x,
    input  logic [COORD_WIDTH-1:0] pixel_y,
    input  logic [ALPHA_W-1:0]     coverage,
    input  logic [CLIP_W-1:0]      clip_left,
    input  logic [CLIP_W-1:0]      clip_top,
    input  logic [CLIP_W-1:0]      clip_right,
    input  logic [CLIP_W-1:0]      clip_bottom,
    input  logic [ALPHA_W-1:0]     const_alpha,
    output ctrl_t                  ctrl
);

    localparam int CMP_W = (COORD_WIDTH > CLIP_W) ? COORD_WIDTH : CLIP_W;

    logic [CMP_W-1:0] x_ext;
    logic [CMP_W-1:0] y_ext;
    logic             in_clip;

    assign x_ext = CMP_W'(pixel_x);
    assign y_ext = CMP_W'(pixel_y);

    // An empty or inverted rectangle contains no pixel
    assign in_clip = (x_ext >= CMP_W'(clip_left))  && (x_ext < CMP_W'(clip_right)) &&
                     (y_ext >= CMP_W'(clip_top))   && (y_ext < CMP_W'(clip_bottom));

    always_comb
    begin
        ctrl.take_src = 1'b0;
        ctrl.take_mix = 1'b0;
        ctrl.alpha    = const_alpha;
        case (req_t'(req_type))
            REQ_FILL:
            begin
                ctrl.take_src = in_clip;
            end
            REQ_CONST:
            begin
                ctrl.take_mix = in_clip && (const_alpha != ALPHA_NONE);
            end
            REQ_COVER:
            begin
                ctrl.alpha    = coverage;
                // full coverage copies the source word, alpha byte included
                ctrl.take_src = in_clip && (coverage == ALPHA_FULL);
                ctrl.take_mix = in_clip && (coverage != ALPHA_NONE) &&
                                (coverage != ALPHA_FULL);
            end
            default:
            begin
                ctrl.take_src = 1'b0;
                ctrl.take_mix = 1'b0;
            end
        endcase
    end

endmodule

/* src/arbc_mix.sv */
`timescale 1ns / 1ps
// ============================================================================
// arbc_mix
// Per-channel blend (src*a + dst*(255-a))/255, truncated, alpha forced opaque.
// ============================================================================
module arbc_mix
    import arbc_pkg::*;
(
    input  logic [PIX_W-1:0]   src,
    input  logic [PIX_W-1:0]   dst,
    input  logic [ALPHA_W-1:0] alpha,
    output logic [PIX_W-1:0]   mixed
);

    logic [ALPHA_W-1:0]    inv_alpha;
    logic [2*CHAN_W-1:0]   sum   [CHAN_N];
    logic [2*CHAN_W:0]     quo   [CHAN_N];
    logic [CHAN_W-1:0]     chan  [CHAN_N];

    assign inv_alpha = ALPHA_FULL - alpha;

    // Divide by 255 as (s + (s >> 8) + 1) >> 8, exact for every sum the blend can form (at most 255*255)
    always_comb
    begin
        for (int c = 0; c < CHAN_N; c++)
        begin
            sum[c]  = (2*CHAN_W)'(src[c*CHAN_W +: CHAN_W] * alpha) +
                      (2*CHAN_W)'(dst[c*CHAN_W +: CHAN_W] * inv_alpha);
            quo[c]  = (2*CHAN_W+1)'(sum[c]) + (2*CHAN_W+1)'(sum[c][2*CHAN_W-1:CHAN_W]) +
                      (2*CHAN_W+1)'(1);
            chan[c] = quo[c][2*CHAN_W-1:CHAN_W];
        end
    end

    assign mixed = {OPAQUE_BYTE, chan[2], chan[1], chan[0]};

endmodule

/* src/argb_rect_blend_compositor_core.sv */
`timescale 1ns / 1ps
// ============================================================================
// argb_rect_blend_compositor_core
// ARGB8888 compositor: clip test, solid fill and alpha blend per pixel.
// ============================================================================
// Takes one pixel word per clock while the input is not stalled and returns
// one result word per pixel, in order, from the result register. A word
// is captured in an input register, passes through the clip test and the
// blend logic (two 8x8 multiplies, an add and a divide by 255 per colour
// channel) combinationally, and lands in the result register; that blend
// path sets the clock period. The input stalls only while both registers are
// full and the output is stalled. Configuration writes take effect at once
// and are meant to be issued while no pixel is in flight.
module argb_rect_blend_compositor_core
    import arbc_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TYPE_W-1:0]     req_type,
    input  logic [COORD_WIDTH-1:0] pixel_x,
    input  logic [COORD_WIDTH-1:0] pixel_y,
    input  logic [PIX_W-1:0]      dest_pixel,
    input  logic [ALPHA_W-1:0]    coverage,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      out_pixel,
    output logic                  modified
);

    logic [CLIP_W-1:0]  clip_left_reg;
    logic [CLIP_W-1:0]  clip_top_reg;
    logic [CLIP_W-1:0]  clip_right_reg;
    logic [CLIP_W-1:0]  clip_bottom_reg;
    logic [PIX_W-1:0]   source_color_reg;
    logic [ALPHA_W-1:0] const_alpha_reg;

    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [TYPE_W-1:0]      s1_type_reg;
    logic [COORD_WIDTH-1:0] s1_x_reg;
    logic [COORD_WIDTH-1:0] s1_y_reg;
    logic [PIX_W-1:0]       s1_dst_reg;
    logic [ALPHA_W-1:0]     s1_cov_reg;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [PIX_W-1:0]       out_pixel_reg;
    logic [PIX_W-1:0]       out_pixel_next;
    logic                   modified_reg;
    logic                   modified_next;

    logic                   out_open;
    logic                   s1_load;
    logic                   s1_move;
    ctrl_t                  ctrl;
    logic [PIX_W-1:0]       mixed;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg    <= '0;
            clip_top_reg     <= '0;
            clip_right_reg   <= '0;
            clip_bottom_reg  <= '0;
            source_color_reg <= SRC_COLOR_RESET;
            const_alpha_reg  <= ALPHA_FULL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLIP_LEFT:    clip_left_reg    <= cfg_data[CLIP_W-1:0];
                CFG_CLIP_TOP:     clip_top_reg     <= cfg_data[CLIP_W-1:0];
                CFG_CLIP_RIGHT:   clip_right_reg   <= cfg_data[CLIP_W-1:0];
                CFG_CLIP_BOTTOM:  clip_bottom_reg  <= cfg_data[CLIP_W-1:0];
                CFG_SOURCE_COLOR: source_color_reg <= cfg_data[PIX_W-1:0];
                CFG_CONST_ALPHA:  const_alpha_reg  <= cfg_data[ALPHA_W-1:0];
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Handshake: the result register frees the input register whenever it
    // is empty or its word is being taken.
    // ---------------------------------------------------------------------
    assign out_open       = !out_valid_reg || !out_stall;
    assign s1_move        = s1_valid_reg && out_open;
    assign in_stall       = s1_valid_reg && !out_open;
    assign s1_load        = in_valid && !in_stall;
    assign s1_valid_next  = s1_load || (s1_valid_reg && !out_open);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_type_reg <= req_type;
            s1_x_reg    <= pixel_x;
            s1_y_reg    <= pixel_y;
            s1_dst_reg  <= dest_pixel;
            s1_cov_reg  <= coverage;
        end
    end

    // ---------------------------------------------------------------------
    // Pixel datapath
    // ---------------------------------------------------------------------
    arbc_decide #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_decide (
        .req_type    (s1_type_reg),
        .pixel_x     (s1_x_reg),
        .pixel_y     (s1_y_reg),
        .coverage    (s1_cov_reg),
        .clip_left   (clip_left_reg),
        .clip_top    (clip_top_reg),
        .clip_right  (clip_right_reg),
        .clip_bottom (clip_bottom_reg),
        .const_alpha (const_alpha_reg),
        .ctrl        (ctrl)
    );

    arbc_mix u_mix (
        .src   (source_color_reg),
        .dst   (s1_dst_reg),
        .alpha (ctrl.alpha),
        .mixed (mixed)
    );

    always_comb
    begin
        if (ctrl.take_src)
        begin
            out_pixel_next = source_color_reg;
        end
        else if (ctrl.take_mix)
        begin
            out_pixel_next = mixed;
        end
        else
        begin
            out_pixel_next = s1_dst_reg;
        end
        modified_next = ctrl.take_src || ctrl.take_mix;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_pixel_reg <= out_pixel_next;
            modified_reg  <= modified_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign modified  = modified_reg;

endmodule

/* src/arbc_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// arbc_checker
// Port-level checks on word flow through the compositor core.
// ============================================================================
module arbc_checker
    import arbc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  logic             out_valid,
    input  logic             out_stall,
    input  logic [PIX_W-1:0] out_pixel,
    input  logic             modified
);

    // words accepted but not yet delivered; the core holds at most two
    logic [1:0] occ_reg;
    logic [1:0] occ_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_acc && !out_acc)
        begin
            occ_next = occ_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            occ_next = occ_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 2'd0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(modified))
        else $error("result word changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != 2'd3)
        else $error("more than two words in flight");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != 2'd0)
        else $error("result word with no accepted input");

endmodule

bind argb_rect_blend_compositor_core arbc_checker u_arbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .modified  (modified)
);
